[hw/rtl/tcw_pkg.sv]
// Shared types and constants of the text console writer.
`default_nettype none

package tcw_pkg;

    // Fixed field widths of the command and result items.
    localparam int CmdW      = 2;
    localparam int CharW     = 8;
    localparam int RowFieldW = 5;
    localparam int ColFieldW = 7;
    localparam int PosW      = 11;
    localparam int CellW     = 16;

    // Wide enough for the largest store that the parameter ranges allow.
    localparam int MaxAddrW = 14;

    localparam int QueueDepth = 2;
    localparam int QueuePtrW  = $clog2(QueueDepth);
    localparam int QueueCntW  = $clog2(QueueDepth + 1);

    localparam logic [CharW-1:0] ChNewline  = 8'd10;
    localparam logic [CharW-1:0] ChReturn   = 8'd13;
    localparam logic [CharW-1:0] ChSpace    = 8'h20;
    localparam logic [CharW-1:0] ResetColor = 8'h07;

    typedef enum logic [CmdW-1:0] {
        CmdPut    = 2'd0,
        CmdClear  = 2'd1,
        CmdSetPos = 2'd2,
        CmdRead   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        OpNone  = 2'd0,
        OpWrite = 2'd1,
        OpFill  = 2'd2,
        OpRead  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        BsInit  = 3'd0,
        BsIdle  = 3'd1,
        BsBlank = 3'd2,
        BsFill  = 3'd3,
        BsDone  = 3'd4
    } t_bstate;

    typedef struct packed {
        logic [RowFieldW-1:0] row;
        logic [ColFieldW-1:0] col;
        logic [PosW-1:0]      pos;
    } t_cursor;

    typedef struct packed {
        t_op                 op;
        logic                scroll;
        logic [CharW-1:0]    ch;
        logic [MaxAddrW-1:0] addr;
        logic [MaxAddrW-1:0] blank_base;
        t_cursor             cursor;
    } t_job;

    typedef struct packed {
        t_cursor          cursor;
        logic [CellW-1:0] cell_data;
    } t_result;

endpackage

`default_nettype wire

[hw/rtl/tcw_if.sv]
// Handshake channels of the text console writer: commands, results and configuration.
`default_nettype none

interface tcw_cmd_if;
    logic                          valid;
    logic                          ready;
    logic [tcw_pkg::CmdW-1:0]      command;
    logic [tcw_pkg::CharW-1:0]     char_code;
    logic [tcw_pkg::RowFieldW-1:0] row;
    logic [tcw_pkg::ColFieldW-1:0] col;

    modport source(output valid, command, char_code, row, col, input ready);
    modport sink(input valid, command, char_code, row, col, output ready);
endinterface

interface tcw_res_if;
    logic                          valid;
    logic                          ready;
    logic [tcw_pkg::RowFieldW-1:0] cursor_row;
    logic [tcw_pkg::ColFieldW-1:0] cursor_col;
    logic [tcw_pkg::PosW-1:0]      cursor_pos;
    logic [tcw_pkg::CellW-1:0]     cell_value;

    modport source(output valid, cursor_row, cursor_col, cursor_pos, cell_value,
                   input ready);
    modport sink(input valid, cursor_row, cursor_col, cursor_pos, cell_value,
                 output ready);
endinterface

interface tcw_cfg_if;
    logic                      valid;
    logic                      ready;
    logic [tcw_pkg::CharW-1:0] text_color;

    modport source(output valid, text_color, input ready);
    modport sink(input valid, text_color, output ready);
endinterface

`default_nettype wire

[hw/rtl/tcw_front.sv]
// Front end: accepts commands, tracks the cursor and the scroll offset, and issues store jobs.
`default_nettype none

module tcw_front #(
    parameter int COLUMNS = 80,
    parameter int LINES   = 25
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tcw_cmd_if.sink       cmd,
    input  logic          i_init_busy,
    input  logic          i_full,
    output logic          o_push,
    output tcw_pkg::t_job o_job
);

    localparam int NCells = LINES * COLUMNS;
    localparam int AddrW  = $clog2(NCells);
    localparam int RowW   = $clog2(LINES);
    localparam int ColW   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;

    localparam logic [RowW-1:0]  LastRow    = RowW'(LINES - 1);
    localparam logic [ColW-1:0]  LastCol    = ColW'(COLUMNS - 1);
    localparam logic [AddrW-1:0] LastRowPos = AddrW'((LINES - 1) * COLUMNS);
    localparam logic [AddrW-1:0] ColStep    = AddrW'(COLUMNS);
    localparam logic [AddrW:0]   CellCount  = (AddrW + 1)'(NCells);

    // The store is a ring of rows: r_top is the store address of the top screen row.
    logic [RowW-1:0]  r_row, n_row;
    logic [ColW-1:0]  r_col, n_col;
    logic [AddrW-1:0] r_pos, n_pos;
    logic [AddrW-1:0] r_top, n_top;

    logic             accept;
    logic [RowW-1:0]  crow;
    logic [ColW-1:0]  ccol;
    logic [AddrW-1:0] tgt_pos;
    logic [AddrW:0]   top_sum;
    logic [AddrW-1:0] top_scrolled;
    tcw_pkg::t_job    job;

    function automatic logic [AddrW-1:0] wrap_addr(input logic [AddrW:0] sum);
        logic [AddrW:0] adj;
        adj = (sum >= CellCount) ? (sum - CellCount) : sum;
        return adj[AddrW-1:0];
    endfunction

    assign cmd.ready = !i_full && !i_init_busy;
    assign accept    = cmd.valid && cmd.ready;
    assign o_push    = accept;
    assign o_job     = job;

    always_comb begin
        crow         = (cmd.row >= LINES) ? LastRow : RowW'(cmd.row);
        ccol         = (cmd.col >= COLUMNS) ? LastCol : ColW'(cmd.col);
        tgt_pos      = AddrW'(crow) * ColStep + AddrW'(ccol);
        top_sum      = {1'b0, r_top} + {1'b0, ColStep};
        top_scrolled = (top_sum == CellCount) ? '0 : top_sum[AddrW-1:0];

        n_row = r_row;
        n_col = r_col;
        n_pos = r_pos;
        n_top = r_top;

        job            = '0;
        job.op         = tcw_pkg::OpNone;
        job.ch         = cmd.char_code;
        job.blank_base = tcw_pkg::MaxAddrW'(r_top);

        unique case (tcw_pkg::t_cmd'(cmd.command))
            tcw_pkg::CmdPut: begin
                priority if (cmd.char_code == tcw_pkg::ChNewline) begin
                    n_col = '0;
                    if (r_row == LastRow) begin
                        job.scroll = 1'b1;
                        n_pos      = LastRowPos;
                        n_top      = top_scrolled;
                    end else begin
                        n_row = r_row + 1'b1;
                        n_pos = r_pos - AddrW'(r_col) + ColStep;
                    end
                end else if (cmd.char_code == tcw_pkg::ChReturn) begin
                    n_col = '0;
                    n_pos = r_pos - AddrW'(r_col);
                end else begin
                    job.op   = tcw_pkg::OpWrite;
                    job.addr = tcw_pkg::MaxAddrW'(wrap_addr({1'b0, r_pos} + {1'b0, r_top}));
                    if (r_col == LastCol) begin
                        n_col = '0;
                        if (r_row == LastRow) begin
                            job.scroll = 1'b1;
                            n_pos      = LastRowPos;
                            n_top      = top_scrolled;
                        end else begin
                            n_row = r_row + 1'b1;
                            n_pos = r_pos + 1'b1;
                        end
                    end else begin
                        n_col = r_col + 1'b1;
                        n_pos = r_pos + 1'b1;
                    end
                end
            end
            tcw_pkg::CmdClear: begin
                job.op = tcw_pkg::OpFill;
                n_row  = '0;
                n_col  = '0;
                n_pos  = '0;
                n_top  = '0;
            end
            tcw_pkg::CmdSetPos: begin
                n_row = crow;
                n_col = ccol;
                n_pos = tgt_pos;
            end
            tcw_pkg::CmdRead: begin
                job.op   = tcw_pkg::OpRead;
                job.addr = tcw_pkg::MaxAddrW'(wrap_addr({1'b0, tgt_pos} + {1'b0, r_top}));
            end
            default: begin
                job.op = tcw_pkg::OpNone;
            end
        endcase

        job.cursor.row = tcw_pkg::RowFieldW'(n_row);
        job.cursor.col = tcw_pkg::ColFieldW'(n_col);
        job.cursor.pos = tcw_pkg::PosW'(n_pos);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row <= '0;
            r_col <= '0;
            r_pos <= '0;
            r_top <= '0;
        end else if (accept) begin
            r_row <= n_row;
            r_col <= n_col;
            r_pos <= n_pos;
            r_top <= n_top;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/tcw_queue.sv]
// Two-entry job queue between the front end and the store engine.
`default_nettype none

module tcw_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  tcw_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output tcw_pkg::t_job o_job,
    output logic          o_empty
);

    tcw_pkg::t_job                    r_slot [tcw_pkg::QueueDepth];
    logic [tcw_pkg::QueuePtrW-1:0]    r_wr_ptr;
    logic [tcw_pkg::QueuePtrW-1:0]    r_rd_ptr;
    logic [tcw_pkg::QueueCntW-1:0]    r_count;
    logic                             do_push;
    logic                             do_pop;

    assign o_full  = (r_count == tcw_pkg::QueueCntW'(tcw_pkg::QueueDepth));
    assign o_empty = (r_count == '0);
    assign o_job   = r_slot[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/tcw_back.sv]
// Store engine: owns the cell memory, runs writes, reads, row blanking and fills, and
// holds the result register.
`default_nettype none

module tcw_back #(
    parameter int COLUMNS = 80,
    parameter int LINES   = 25
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [tcw_pkg::CharW-1:0]  i_color,
    input  tcw_pkg::t_job              i_job,
    input  logic                       i_empty,
    output logic                       o_pop,
    output logic                       o_init_busy,
    tcw_res_if.source                  res
);

    localparam int NCells = LINES * COLUMNS;
    localparam int AddrW  = $clog2(NCells);

    localparam logic [AddrW-1:0] LastCell = AddrW'(NCells - 1);
    localparam logic [AddrW-1:0] LastCol  = AddrW'(COLUMNS - 1);

    logic [tcw_pkg::CellW-1:0] r_mem [NCells];
    logic [tcw_pkg::CellW-1:0] r_rd_data;

    tcw_pkg::t_bstate  r_state, n_state;
    tcw_pkg::t_job     r_job;
    logic [AddrW-1:0]  r_cnt;
    logic [AddrW-1:0]  r_base;
    logic              r_out_valid;
    tcw_pkg::t_result  r_out;

    logic                      out_free;
    logic                      can_start;
    logic                      pop;
    logic                      emit;
    logic                      last_cell;
    logic                      last_col;
    logic                      mem_we;
    logic [AddrW-1:0]          mem_waddr;
    logic [tcw_pkg::CellW-1:0] mem_wdata;
    logic                      mem_re;
    logic [tcw_pkg::CellW-1:0] blank;

    assign out_free  = !r_out_valid || res.ready;
    assign emit      = (r_state == tcw_pkg::BsDone) && out_free;
    // A finished job hands over its result in the same cycle that the next job starts.
    assign can_start = (r_state == tcw_pkg::BsIdle) || emit;
    assign pop       = can_start && !i_empty;
    assign last_cell = (r_cnt == LastCell);
    assign last_col  = (r_cnt == LastCol);
    assign blank     = {i_color, tcw_pkg::ChSpace};

    assign o_pop       = pop;
    assign o_init_busy = (r_state == tcw_pkg::BsInit);

    assign res.valid      = r_out_valid;
    assign res.cursor_row = r_out.cursor.row;
    assign res.cursor_col = r_out.cursor.col;
    assign res.cursor_pos = r_out.cursor.pos;
    assign res.cell_value = r_out.cell_data;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tcw_pkg::BsInit: begin
                if (last_cell) begin
                    n_state = tcw_pkg::BsIdle;
                end
            end
            tcw_pkg::BsIdle, tcw_pkg::BsDone: begin
                if (pop) begin
                    if (i_job.op == tcw_pkg::OpFill) begin
                        n_state = tcw_pkg::BsFill;
                    end else if (i_job.scroll) begin
                        n_state = tcw_pkg::BsBlank;
                    end else begin
                        n_state = tcw_pkg::BsDone;
                    end
                end else if (can_start) begin
                    n_state = tcw_pkg::BsIdle;
                end
            end
            tcw_pkg::BsBlank: begin
                if (last_col) begin
                    n_state = tcw_pkg::BsDone;
                end
            end
            tcw_pkg::BsFill: begin
                if (last_cell) begin
                    n_state = tcw_pkg::BsDone;
                end
            end
            default: begin
                n_state = tcw_pkg::BsIdle;
            end
        endcase
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_cnt;
        mem_wdata = blank;
        mem_re    = 1'b0;
        unique case (r_state)
            tcw_pkg::BsInit: begin
                mem_we    = 1'b1;
                mem_wdata = {tcw_pkg::ResetColor, tcw_pkg::ChSpace};
            end
            tcw_pkg::BsFill: begin
                mem_we = 1'b1;
            end
            tcw_pkg::BsBlank: begin
                mem_we    = 1'b1;
                mem_waddr = r_base + r_cnt;
            end
            tcw_pkg::BsIdle, tcw_pkg::BsDone: begin
                mem_we    = pop && (i_job.op == tcw_pkg::OpWrite);
                mem_waddr = AddrW'(i_job.addr);
                mem_wdata = {i_color, i_job.ch};
                mem_re    = pop && (i_job.op == tcw_pkg::OpRead);
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            r_rd_data <= r_mem[AddrW'(i_job.addr)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_job  <= i_job;
            r_base <= AddrW'(i_job.blank_base);
        end
        if (emit) begin
            r_out.cursor    <= r_job.cursor;
            r_out.cell_data <= (r_job.op == tcw_pkg::OpRead) ? r_rd_data : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tcw_pkg::BsInit;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (pop) begin
                r_cnt <= '0;
            end else if ((r_state == tcw_pkg::BsInit) || (r_state == tcw_pkg::BsFill)) begin
                r_cnt <= last_cell ? '0 : r_cnt + 1'b1;
            end else if (r_state == tcw_pkg::BsBlank) begin
                r_cnt <= last_col ? '0 : r_cnt + 1'b1;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

[hw/rtl/text_console_writer.sv]
// Text console writer top level: LINES x COLUMNS cell store with cursor, scrolling and clear.
//
// The block keeps a LINES x COLUMNS store of 16-bit cells (color byte above character
// byte) in one single-port-write, registered-read memory used as a ring of rows, so a
// scroll only moves the top-row offset and blanks one row. After reset the store is
// swept to blank cells (color 0x07), and no command item is accepted during the sweep;
// configuration writes are taken at any time. Put character, carriage return, newline
// without scrolling, set position and read cell each need only the Done state of the
// store engine, so such items stream at one item per cycle while each result is taken
// as it is emitted. An item that scrolls also blanks the new bottom row in the Blank
// state, and clear sweeps the full store in the Fill state; both are bound by the one
// memory write port. A result passes the queue slot, the job register and the result
// register. A two-entry queue separates command intake from the store engine, and the
// result register lets the next item proceed while a finished result waits to be taken.
`default_nettype none

module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int LINES   = 25
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    tcw_cmd_if.sink   i_cmd,
    tcw_res_if.source o_res,
    tcw_cfg_if.sink   i_cfg
);

    logic [tcw_pkg::CharW-1:0] r_text_color;
    logic                      init_busy;
    logic                      q_full;
    logic                      q_empty;
    logic                      push;
    logic                      pop;
    tcw_pkg::t_job             front_job;
    tcw_pkg::t_job             queue_job;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color <= tcw_pkg::ResetColor;
        end else if (i_cfg.valid) begin
            r_text_color <= i_cfg.text_color;
        end
    end

    tcw_front #(
        .COLUMNS(COLUMNS),
        .LINES  (LINES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .cmd        (i_cmd),
        .i_init_busy(init_busy),
        .i_full     (q_full),
        .o_push     (push),
        .o_job      (front_job)
    );

    tcw_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_job  (front_job),
        .o_full (q_full),
        .i_pop  (pop),
        .o_job  (queue_job),
        .o_empty(q_empty)
    );

    tcw_back #(
        .COLUMNS(COLUMNS),
        .LINES  (LINES)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_color    (r_text_color),
        .i_job      (queue_job),
        .i_empty    (q_empty),
        .o_pop      (pop),
        .o_init_busy(init_busy),
        .res        (o_res)
    );

endmodule

`default_nettype wire

[hw/rtl/tcw_checker.sv]
// Port-level assertions for the text console writer and the bind that attaches them.
`default_nettype none

module tcw_checker #(
    parameter int COLUMNS = 80,
    parameter int LINES   = 25
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_in_valid,
    input logic                          i_in_ready,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [tcw_pkg::RowFieldW-1:0] i_cursor_row,
    input logic [tcw_pkg::ColFieldW-1:0] i_cursor_col,
    input logic [tcw_pkg::PosW-1:0]      i_cursor_pos,
    input logic [tcw_pkg::CellW-1:0]     i_cell_value
);

    // The position check only holds where the reported row and column are not truncated.
    localparam bit Narrow = (LINES <= 32) && (COLUMNS <= 128);

    logic       in_acc;
    logic       out_acc;
    logic [3:0] r_pending;

    assign in_acc  = i_in_valid && i_in_ready;
    assign out_acc = i_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= r_pending + {3'b000, in_acc} - {3'b000, out_acc};
        end
    end

    // Every delivered result belongs to an item taken earlier.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc |-> (r_pending != 4'd0))
        else $error("result delivered with no item outstanding");

    // The store is still being swept right after reset, so no item may enter.
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !i_in_ready)
        else $error("item accepted during the post-reset sweep");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_cursor_row) && $stable(i_cursor_col)
             && $stable(i_cursor_pos) && $stable(i_cell_value)))
        else $error("stalled result changed or dropped");

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (!Narrow ||
            ((i_cursor_pos == tcw_pkg::PosW'(int'(i_cursor_row) * COLUMNS
                                             + int'(i_cursor_col)))
             && (int'(i_cursor_col) < COLUMNS) && (int'(i_cursor_row) < LINES))))
        else $error("reported cursor position is inconsistent");

endmodule

bind text_console_writer tcw_checker #(
    .COLUMNS(COLUMNS),
    .LINES  (LINES)
) u_tcw_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_cmd.valid),
    .i_in_ready  (i_cmd.ready),
    .i_out_valid (o_res.valid),
    .i_out_ready (o_res.ready),
    .i_cursor_row(o_res.cursor_row),
    .i_cursor_col(o_res.cursor_col),
    .i_cursor_pos(o_res.cursor_pos),
    .i_cell_value(o_res.cell_value)
);

`default_nettype wire
